/* src/fccc_pkg.sv */
// Package for the FAT chain consistency checker.
// Command and finding codes, the result record type and shared widths.
package fccc_pkg;

  localparam int CMD_W = 2;
  localparam int FND_W = 3;
  localparam int CL_W  = 16;
  localparam int VAL_W = 17;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

  localparam logic [FND_W-1:0] FND_CLEAN   = 3'd0;
  localparam logic [FND_W-1:0] FND_INVALID = 3'd1;
  localparam logic [FND_W-1:0] FND_LOOP    = 3'd2;
  localparam logic [FND_W-1:0] FND_XLINK   = 3'd3;
  localparam logic [FND_W-1:0] FND_READ    = 3'd4;

  localparam logic [VAL_W-1:0] VAL_EOC     = 17'h1FFFF;
  localparam logic [VAL_W-1:0] VAL_INVALID = 17'd1;

  typedef struct packed {
    logic [FND_W-1:0] finding;
    logic [CL_W-1:0]  at_cluster;
    logic [CL_W-1:0]  other_cluster;
    logic             repaired;
    logic             fatal;
    logic [VAL_W-1:0] read_value;
  } res_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } vis_cmd_t;

endpackage

/* src/fccc_visit.sv */
// Visited map for the chain walk, kept as an epoch mark per cluster.
// Depends on fccc_pkg. Read data is registered; hit compares it to the epoch.
module fccc_visit #(
  parameter int CLUSTERS = 65536,
  parameter int EP_W     = 16
) (
  input  logic                        clk,
  input  fccc_pkg::vis_cmd_t          cmd,
  input  logic [$clog2(CLUSTERS)-1:0] wr_addr,
  input  logic [EP_W-1:0]             wr_mark,
  input  logic [$clog2(CLUSTERS)-1:0] rd_addr,
  input  logic [EP_W-1:0]             epoch,
  output logic                        hit
);
  localparam int AW = $clog2(CLUSTERS);

  logic [EP_W-1:0] mem [CLUSTERS];
  logic [EP_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_mark;
    end
    if (cmd.rd) begin
      q_r <= mem[rd_addr];
    end
  end

  assign hit = (q_r == epoch) && (epoch != '0) && (AW > 0);
endmodule

/* src/fat_chain_consistency_checker.sv */
// FAT chain consistency checker, top level.
// Depends on fccc_pkg and fccc_visit. Holds the FAT and referrer memories.
// A write gives no result; a read gives one result word.
// A check reads the start entry, then walks the chain (mark and FAT read, then visited read
// and hit test, per step), runs the referrer test, then sends its result words one at a time.
// Reset (rst_n low, synchronous) starts a sweep over all CLUSTERS addresses that clears
// the referrer and visited memories; every 65535 walks a visited sweep over all
// addresses runs. Config writes are taken at any time. One item at a time.
module fat_chain_consistency_checker #(
  parameter int CLUSTERS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cluster[15:0], entry_value[32:16], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // at_cluster, other_cluster, repaired, fatal,
                                  // read_value[50:34], zero pad
  output logic [2:0]  out_tuser,  // finding[2:0]
  output logic        out_tlast
);
  localparam int AW   = $clog2(CLUSTERS);
  localparam int EP_W = 16;
  localparam logic [16:0] CL17 = 17'(CLUSTERS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CLUSTERS - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RDAT, S_VAL, S_VCLR, S_WRD, S_WNX, S_WVC,
    S_XRD, S_XCHK, S_XFIX, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] max_r;
  logic        rep_r;
  logic [15:0] c_r, c_nxt;
  logic [16:0] val_r, val_nxt;
  logic [AW-1:0] cur_r, cur_nxt, nx_r, nx_nxt, swp_r, swp_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [EP_W-1:0] ep_r, ep_nxt;
  logic [1:0] n_r, n_nxt, oi_r, oi_nxt;
  logic       initref_r, initref_nxt;
  fccc_pkg::res_t res_r [3];
  fccc_pkg::res_t out_r;
  logic       out_v_r, out_v_nxt, out_last_r;
  logic       load;

  logic [16:0] fat_mem [CLUSTERS];
  logic [15:0] ref_mem [CLUSTERS];
  logic [16:0] fat_q;
  logic [15:0] ref_q;

  logic          fat_we, fat_re, ref_we, ref_re;
  logic [AW-1:0] fat_wa, fat_ra, ref_wa, ref_ra, vis_wa, vis_ra;
  logic [16:0]   fat_wd;
  logic [15:0]   ref_wd;
  logic [EP_W-1:0] vis_wd;
  fccc_pkg::vis_cmd_t vis_cmd;
  logic          vis_hit;
  logic          add;
  fccc_pkg::res_t add_res;

  logic [1:0]  in_cmd;
  logic [15:0] in_cl;
  logic [16:0] in_ev;
  logic        in_acc;

  function automatic logic in_range(input logic [16:0] x, input logic [15:0] mx);
    in_range = !x[16] && (x[15:0] >= 16'd2) && (x[15:0] <= mx) && (x < CL17);
  endfunction

  function automatic logic below(input logic [15:0] x);
    below = {1'b0, x} < CL17;
  endfunction

  assign in_cmd    = in_tuser;
  assign in_cl     = in_tdata[15:0];
  assign in_ev     = in_tdata[32:16];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  fccc_visit #(.CLUSTERS(CLUSTERS), .EP_W(EP_W)) u_visit (
    .clk(clk), .cmd(vis_cmd), .wr_addr(vis_wa), .wr_mark(vis_wd),
    .rd_addr(vis_ra), .epoch(ep_r), .hit(vis_hit)
  );

  always_comb begin
    state_nxt = state_r;
    c_nxt = c_r; val_nxt = val_r; cur_nxt = cur_r; nx_nxt = nx_r;
    swp_nxt = swp_r; prev_nxt = prev_r; ep_nxt = ep_r; n_nxt = n_r;
    oi_nxt = oi_r; initref_nxt = initref_r;
    fat_we = 1'b0; fat_re = 1'b0; ref_we = 1'b0; ref_re = 1'b0;
    fat_wa = cur_r; fat_ra = cur_r; fat_wd = fccc_pkg::VAL_EOC;
    ref_wa = val_r[AW-1:0]; ref_ra = val_r[AW-1:0]; ref_wd = c_r;
    vis_cmd = '0; vis_wa = cur_r; vis_ra = nx_r; vis_wd = ep_r;
    add = 1'b0; add_res = '0; add_res.at_cluster = c_r;
    load = 1'b0;
    out_v_nxt = out_v_r && !out_tready;
    case (state_r)
      S_INIT, S_VCLR: begin
        vis_cmd.wr = 1'b1; vis_wa = swp_r; vis_wd = '0;
        ref_we = initref_r; ref_wa = swp_r; ref_wd = '0;
        swp_nxt = swp_r + 1'b1;
        if (swp_r == LAST_ADDR) begin
          ep_nxt = EP_W'(1);
          initref_nxt = 1'b0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_WRD;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          c_nxt = in_cl; n_nxt = '0; oi_nxt = '0;
          case (in_cmd)
            fccc_pkg::CMD_WRITE: begin
              fat_we = below(in_cl); fat_wa = in_cl[AW-1:0]; fat_wd = in_ev;
            end
            fccc_pkg::CMD_READ: begin
              fat_re = below(in_cl); fat_ra = in_cl[AW-1:0]; state_nxt = S_RDAT;
            end
            fccc_pkg::CMD_CHECK: begin
              if (in_range({1'b0, in_cl}, max_r)) begin
                fat_re = 1'b1; fat_ra = in_cl[AW-1:0]; state_nxt = S_VAL;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDAT: begin
        add = 1'b1; add_res.finding = fccc_pkg::FND_READ;
        add_res.read_value = below(c_r) ? fat_q : '0;
        state_nxt = S_FIN;
      end
      S_VAL: begin
        val_nxt = fat_q;
        cur_nxt = c_r[AW-1:0];
        if (fat_q == '0) begin
          state_nxt = S_XRD;
        end else begin
          if (fat_q == fccc_pkg::VAL_INVALID) begin
            add = 1'b1; add_res.finding = fccc_pkg::FND_INVALID;
            add_res.repaired = rep_r; add_res.fatal = !rep_r;
            fat_we = rep_r; fat_wa = c_r[AW-1:0];
          end
          if (ep_r == '1) begin
            swp_nxt = '0; state_nxt = S_VCLR;
          end else begin
            ep_nxt = ep_r + 1'b1; state_nxt = S_WRD;
          end
        end
      end
      S_WRD: begin
        vis_cmd.wr = 1'b1; fat_re = 1'b1;
        state_nxt = S_WNX;
      end
      S_WNX: begin
        if (in_range(fat_q, max_r)) begin
          nx_nxt = fat_q[AW-1:0];
          vis_cmd.rd = 1'b1; vis_ra = fat_q[AW-1:0];
          state_nxt = S_WVC;
        end else begin
          state_nxt = S_XRD;
        end
      end
      S_WVC: begin
        if (vis_hit) begin
          add = 1'b1; add_res.finding = fccc_pkg::FND_LOOP;
          add_res.at_cluster = 16'(cur_r);
          add_res.repaired = rep_r; add_res.fatal = !rep_r;
          fat_we = rep_r;
          state_nxt = rep_r ? S_XRD : S_FIN;
        end else begin
          cur_nxt = nx_r; state_nxt = S_WRD;
        end
      end
      S_XRD: begin
        if (in_range(val_r, max_r)) begin
          ref_re = 1'b1; state_nxt = S_XCHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_XCHK: begin
        ref_we = 1'b1;
        prev_nxt = ref_q;
        state_nxt = S_FIN;
        if (ref_q != '0) begin
          add = 1'b1; add_res.finding = fccc_pkg::FND_XLINK;
          add_res.other_cluster = ref_q; add_res.repaired = rep_r;
          fat_we = rep_r; fat_wa = c_r[AW-1:0];
          if (rep_r) state_nxt = S_XFIX;
        end
      end
      S_XFIX: begin
        fat_we = below(prev_r); fat_wa = prev_r[AW-1:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (n_r == '0) begin
          add = 1'b1; add_res.finding = fccc_pkg::FND_CLEAN;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_v_r || out_tready) begin
          if (oi_r != n_r) begin
            load = 1'b1; out_v_nxt = 1'b1; oi_nxt = oi_r + 1'b1;
            if (oi_r + 1'b1 == n_r) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (add) n_nxt = n_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (fat_we) fat_mem[fat_wa] <= fat_wd;
    if (fat_re) fat_q <= fat_mem[fat_ra];
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
    if (ref_re) ref_q <= ref_mem[ref_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; max_r <= 16'hFFFF; rep_r <= 1'b0;
      swp_r <= '0; ep_r <= '0; n_r <= '0; oi_r <= '0;
      initref_r <= 1'b1; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; swp_r <= swp_nxt; ep_r <= ep_nxt;
      n_r <= n_nxt; oi_r <= oi_nxt; initref_r <= initref_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) begin
        if (cfg_index) rep_r <= cfg_wdata[0];
        else           max_r <= cfg_wdata;
      end
    end
    c_r <= c_nxt; val_r <= val_nxt; cur_r <= cur_nxt; nx_r <= nx_nxt;
    prev_r <= prev_nxt;
    if (add) res_r[n_r] <= add_res;
    if (load) begin
      out_r      <= res_r[oi_r];
      out_last_r <= (oi_r + 1'b1 == n_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.finding;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_r.read_value, out_r.fatal, out_r.repaired,
                       out_r.other_cluster, out_r.at_cluster};

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (n_r != 2'd0))
    else $error("result count is zero at output");
  a_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRD) |-> (ep_r != '0))
    else $error("walk runs with reserved epoch");
  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    add |-> (n_r != 2'd3))
    else $error("result buffer overflow");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == fccc_pkg::CMD_WRITE)) |=> (state_r == S_IDLE))
    else $error("write left idle state");
endmodule

/* verif/fccc_checker.sv */
// Checker for the FAT chain consistency checker: watches the config port and both streams.
// Keeps its own FAT, referrer and visited state and compares every result word in order.
// Depends on fccc_pkg.
`timescale 1ns / 100ps
module fccc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);

  typedef struct {
    fccc_pkg::res_t r;
    logic last;
  } finding_word_t;

  localparam int EOC = -1;

  finding_word_t finding_q[$];
  int            fat_mem[int];
  logic [15:0]   refr_mem[int];
  bit            seen[int];
  int            max_cl;
  bit            repair_on;

  function automatic bit valid_cl(int c);
    return c >= 2 && c <= max_cl && c < 65536;
  endfunction

  task automatic push_word(logic [2:0] f, int at, int oth, bit rep, bit fat, int rv);
    finding_word_t w;
    w.r.finding       = f;
    w.r.at_cluster    = at[15:0];
    w.r.other_cluster = oth[15:0];
    w.r.repaired      = rep;
    w.r.fatal         = fat;
    w.r.read_value    = rv[16:0];
    w.last            = 1'b0;
    finding_q.push_back(w);
  endtask

  function automatic int fat_rd(int c);
    return fat_mem.exists(c) ? fat_mem[c] : 0;
  endfunction

  task automatic predict_check(int c);
    int  n0, val, cur, nxt, prv;
    bit  stop;
    n0 = finding_q.size();
    stop = 0;
    if (!valid_cl(c)) begin
      push_word(fccc_pkg::FND_CLEAN, c, 0, 0, 0, 0);
      return;
    end
    val = fat_rd(c);
    if (val != 0) begin
      if (val == 1) begin
        if (repair_on) begin
          fat_mem[c] = EOC;
          push_word(fccc_pkg::FND_INVALID, c, 0, 1, 0, 0);
        end else begin
          push_word(fccc_pkg::FND_INVALID, c, 0, 0, 1, 0);
        end
      end
      seen.delete();
      cur = c;
      while (valid_cl(cur) && !stop) begin
        seen[cur] = 1;
        nxt = fat_rd(cur);
        if (valid_cl(nxt) && seen.exists(nxt)) begin
          if (repair_on) begin
            fat_mem[cur] = EOC;
            push_word(fccc_pkg::FND_LOOP, cur, 0, 1, 0, 0);
            stop = 1;
          end else begin
            push_word(fccc_pkg::FND_LOOP, cur, 0, 0, 1, 0);
            return;
          end
        end
        cur = nxt;
      end
    end
    if (valid_cl(val)) begin
      prv = refr_mem.exists(val) ? int'(refr_mem[val]) : 0;
      if (prv != 0) begin
        if (repair_on) begin
          fat_mem[c] = EOC;
          fat_mem[prv] = EOC;
          push_word(fccc_pkg::FND_XLINK, c, prv, 1, 0, 0);
        end else begin
          push_word(fccc_pkg::FND_XLINK, c, prv, 0, 0, 0);
        end
      end
      refr_mem[val] = c[15:0];
    end
    if (finding_q.size() == n0) push_word(fccc_pkg::FND_CLEAN, c, 0, 0, 0, 0);
  endtask

  always @(posedge clk) begin
    int             c, ev, sz;
    finding_word_t  w;
    fccc_pkg::res_t got;
    if (!rst_n) begin
      max_cl = 65535;
      repair_on = 0;
      fat_mem.delete();
      refr_mem.delete();
      finding_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == 1'b0) max_cl = cfg_wdata;
        else repair_on = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) begin
        c = in_tdata[15:0];
        ev = int'($signed(in_tdata[32:16]));
        sz = finding_q.size();
        if (in_tuser == fccc_pkg::CMD_WRITE) fat_mem[c] = ev;
        else if (in_tuser == fccc_pkg::CMD_READ)
          push_word(fccc_pkg::FND_READ, c, 0, 0, 0, fat_rd(c));
        else if (in_tuser == fccc_pkg::CMD_CHECK) predict_check(c);
        if (finding_q.size() > sz) finding_q[$].last = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.finding       = out_tuser;
        got.at_cluster    = out_tdata[15:0];
        got.other_cluster = out_tdata[31:16];
        got.repaired      = out_tdata[32];
        got.fatal         = out_tdata[33];
        got.read_value    = out_tdata[50:34];
        if (finding_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual %p last %b",
                   $time, got, out_tlast);
        end else begin
          w = finding_q.pop_front();
          if (got !== w.r || out_tlast !== w.last) begin
            errors++;
            $display("%0t: mismatch: expected %p last %b, actual %p last %b",
                     $time, w.r, w.last, got, out_tlast);
          end
        end
      end
    end
    pending = finding_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

/* verif/testbench.sv */
// Testbench top for the FAT chain consistency checker: clock, reset, stimulus and verdict.
// Entries read or walked stay inside a small written cluster pool.
// Depends on fccc_pkg, fccc_checker and the block.
`timescale 1ns / 100ps
module testbench;

  localparam int LIMIT = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_wdata = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          errors, pending;
  bit          quiet = 0;
  bit          hold = 0;
  int          cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  fat_chain_consistency_checker dut (.*);

  fccc_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold) out_tready <= 1'b0;
    else out_tready <= quiet || $urandom_range(99) >= 13;
  end

  function automatic int pool_cl(int i);
    return i < 14 ? i : 65520 + i;
  endfunction

  function automatic int rand_val();
    int k;
    k = $urandom_range(9);
    if (k == 0) return -1;
    if (k == 1) return 0;
    if (k == 2) return 1;
    return pool_cl($urandom_range(15));
  endfunction

  task automatic send(logic [1:0] cmd, int cl, int val);
    while (!quiet && $urandom_range(99) < 13) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser  = cmd;
    in_tdata  = {7'd0, val[16:0], cl[15:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_cfg(int mx, bit rep);
    cfg_wr_en = 1; cfg_index = 0; cfg_wdata = mx[15:0];
    @(negedge clk);
    cfg_index = 1; cfg_wdata = {15'd0, rep};
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic random_phase(int n);
    int i, k;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) send(fccc_pkg::CMD_WRITE, pool_cl($urandom_range(15)), rand_val());
      else if (k < 80) send(fccc_pkg::CMD_CHECK, pool_cl($urandom_range(15)), $urandom);
      else if (k < 90) send(fccc_pkg::CMD_READ, pool_cl($urandom_range(15)), $urandom);
      else if (k < 95) send(fccc_pkg::CMD_WRITE, $urandom_range(16, 65519), $urandom);
      else send(fccc_pkg::CMD_RSVD, $urandom, $urandom);
    end
  endtask

  initial begin
    int i;
    repeat (6) @(negedge clk);
    rst_n = 1;
    for (i = 0; i < 16; i++) send(fccc_pkg::CMD_WRITE, pool_cl(i), -1);
    drain();
    set_cfg(65535, 0);
    send(fccc_pkg::CMD_WRITE, 2, 3);
    send(fccc_pkg::CMD_WRITE, 3, 4);
    send(fccc_pkg::CMD_CHECK, 2, 0);
    send(fccc_pkg::CMD_WRITE, 5, 1);
    send(fccc_pkg::CMD_CHECK, 5, 0);
    send(fccc_pkg::CMD_WRITE, 6, 7);
    send(fccc_pkg::CMD_WRITE, 7, 6);
    send(fccc_pkg::CMD_CHECK, 6, 0);
    send(fccc_pkg::CMD_CHECK, 3, 0);
    send(fccc_pkg::CMD_WRITE, 8, 4);
    send(fccc_pkg::CMD_CHECK, 8, 0);
    send(fccc_pkg::CMD_CHECK, 0, 0);
    send(fccc_pkg::CMD_CHECK, 65535, 0);
    send(fccc_pkg::CMD_READ, 65535, 0);
    send(fccc_pkg::CMD_READ, 0, 0);
    send(fccc_pkg::CMD_RSVD, 65535, -1);
    send(fccc_pkg::CMD_WRITE, 65534, 65535);
    send(fccc_pkg::CMD_WRITE, 65535, 65534);
    send(fccc_pkg::CMD_CHECK, 65535, 0);
    drain();
    set_cfg(65535, 1);
    send(fccc_pkg::CMD_CHECK, 5, 0);
    send(fccc_pkg::CMD_CHECK, 6, 0);
    send(fccc_pkg::CMD_CHECK, 65534, 0);
    send(fccc_pkg::CMD_CHECK, 3, 0);
    drain();
    set_cfg(13, 1);
    random_phase(60);
    drain();
    set_cfg(2, 0);
    random_phase(40);
    drain();
    set_cfg(65534, 1);
    quiet = 1;
    random_phase(50);
    quiet = 0;
    fork
      begin
        hold = 1;
        repeat (400) @(negedge clk);
        hold = 0;
      end
      random_phase(30);
    join
    drain();
    set_cfg(65535, 0);
    random_phase(60);
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
